// File: design/dtbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbl_pkg - shared definitions for the dual token bucket limiter
// Field widths, register indexes and constants shared by the limiter,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package dtbl_pkg;

  localparam int unsigned NOW_W   = 32;
  localparam int unsigned SPEND_W = 20;
  localparam int unsigned LIMIT_W = 28;
  localparam int unsigned LEFT_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  // Minimum spacing between refills, in milliseconds
  localparam logic [NOW_W-1:0] REFILL_PERIOD_MS = 32'd500;

  // Limit and bucket value after reset, also what a written zero means
  localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 28'hFFF_FFFF;
  // LIMIT_DEFAULT split into quotient and remainder by 1000
  localparam logic [18:0] LIMIT_Q_DEFAULT = 19'd268435;
  localparam logic [9:0]  LIMIT_R_DEFAULT = 10'd455;

  // floor(x / 1000) = (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
  localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
  localparam int unsigned DIV1000_SHIFT = 38;
  // floor(x / 1000) = (x * SDIV1000_MAGIC) >> SDIV1000_SHIFT for any 20-bit x
  localparam logic [20:0] SDIV1000_MAGIC = 21'd1073742;
  localparam int unsigned SDIV1000_SHIFT = 30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_UP_LIMIT   = 2'd0,
    CFG_DOWN_LIMIT = 2'd1
  } cfg_reg_t;

endpackage

// File: design/dtbl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbl_in_if - byte accounting input channel
// Valid/ready channel carrying the time stamp and the bytes spent.
// ----------------------------------------------------------------------------
interface dtbl_in_if;
  import dtbl_pkg::*;

  logic               valid;
  logic               ready;
  logic [NOW_W-1:0]   now_ms;
  logic [SPEND_W-1:0] up_spend;
  logic [SPEND_W-1:0] down_spend;

  modport source (output valid, output now_ms, output up_spend, output down_spend,
                  input ready);
  modport sink   (input valid, input now_ms, input up_spend, input down_spend,
                  output ready);
endinterface

// File: design/dtbl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbl_out_if - credit result channel
// Valid/ready channel carrying the credit left in each bucket.
// ----------------------------------------------------------------------------
interface dtbl_out_if;
  import dtbl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [LEFT_W-1:0] up_left;
  logic signed [LEFT_W-1:0] down_left;
  logic                     refilled;

  modport source (output valid, output up_left, output down_left, output refilled,
                  input ready);
  modport sink   (input valid, input up_left, input down_left, input refilled,
                  output ready);
endinterface

// File: design/dtbl_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbl_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface dtbl_cfg_if;
  import dtbl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [LIMIT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/dual_token_bucket_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_token_bucket_limiter_top - upload/download byte credit limiter
//
// Usage:
//   in_ch  : one transaction per accounting event: now_ms (free-running
//            millisecond tick), up_spend and down_spend in bytes.
//   out_ch : one transaction per input: credit left in each bucket after
//            refill and spend, and a flag for events that refilled.
//   cfg_ch : register writes (index 0 upload limit, 1 download limit);
//            always ready, write only while no transaction is in flight.
//            A limit of zero stands for the maximum 0x0FFFFFFF.
// Pipeline: input stage, divide-by-1000 stage, partial product stage, gain
//   sum stage and output register, in that order, from in_ch to out_ch.
// Throughput: one transaction per cycle unless out_ch stalls. The refill
//   reference time is updated in the first stage and the bucket in the
//   last, each by a single subtract/compare or add/cap/subtract, so items
//   follow back to back.
// Reset (rst_n low, synchronous): pipeline empties, limits and buckets go
//   to 0x0FFFFFFF, and the next transaction only records its time.
// Stall: the output register holds its transaction while out_ch.ready is
//   low; stages behind it keep filling, and in_ch.ready drops only once all
//   five stages hold a transaction.
// ----------------------------------------------------------------------------
module dual_token_bucket_limiter_top (
  input  logic      clk,
  input  logic      rst_n,
  dtbl_in_if.sink   in_ch,
  dtbl_out_if.source out_ch,
  dtbl_cfg_if.sink  cfg_ch
);
  import dtbl_pkg::*;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Sum the partial gains, finish the small divide, clip to 33 bits.
  // Any gain of 2^33 or more lifts every bucket past its cap anyway.
  function automatic logic [32:0] gain_finish(input logic [50:0] t1,
                                              input logic [27:0] t3,
                                              input logic [19:0] t4);
    logic [40:0] q_prod;
    logic [9:0]  t4q;
    logic [51:0] total;
    q_prod = 41'(t4) * 41'(SDIV1000_MAGIC);
    t4q    = q_prod[SDIV1000_SHIFT +: 10];
    total  = 52'(t1) + 52'(t3) + 52'(t4q);
    if (|total[51:33]) begin
      gain_finish = '1;
    end else begin
      gain_finish = total[32:0];
    end
  endfunction

  // Refill (add, cap at limit), then spend with saturation at -2^31.
  function automatic logic signed [LEFT_W-1:0] bucket_step(
      input logic signed [LEFT_W-1:0] bucket,
      input logic [32:0]              gain,
      input logic                     refill,
      input logic [LIMIT_W-1:0]       limit,
      input logic [SPEND_W-1:0]       spend);
    logic signed [34:0] sum;
    logic signed [34:0] lim_s;
    logic signed [34:0] capped;
    logic signed [34:0] rem;
    logic signed [34:0] floor_s;
    sum     = 35'(bucket) + $signed({2'b00, gain});
    lim_s   = $signed({7'd0, limit});
    floor_s = $signed({3'b111, 1'b1, 31'd0});
    if (!refill) begin
      capped = 35'(bucket);
    end else if (sum > lim_s) begin
      capped = lim_s;
    end else begin
      capped = sum;
    end
    rem = capped - $signed({15'd0, spend});
    if (rem < floor_s) begin
      rem = floor_s;
    end
    bucket_step = rem[LEFT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // Hold each limit with its quotient and remainder by 1000 so the refill
  // path never divides a wide product.
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] up_limit_r, down_limit_r;
  logic [18:0]        up_lq_r, down_lq_r;
  logic [9:0]         up_lr_r, down_lr_r;

  logic [LIMIT_W-1:0] cfg_limit;
  logic [56:0]        cfg_q_prod;
  logic [18:0]        cfg_lq;
  logic [LIMIT_W-1:0] cfg_rem;
  logic               cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_comb begin
    cfg_limit  = (cfg_ch.data == '0) ? LIMIT_DEFAULT : cfg_ch.data;
    cfg_q_prod = 57'(cfg_limit) * 57'(DIV1000_MAGIC);
    cfg_lq     = cfg_q_prod[DIV1000_SHIFT +: 19];
    cfg_rem    = cfg_limit - (28'(cfg_lq) * 28'd1000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_limit_r   <= LIMIT_DEFAULT;
      up_lq_r      <= LIMIT_Q_DEFAULT;
      up_lr_r      <= LIMIT_R_DEFAULT;
      down_limit_r <= LIMIT_DEFAULT;
      down_lq_r    <= LIMIT_Q_DEFAULT;
      down_lr_r    <= LIMIT_R_DEFAULT;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_UP_LIMIT: begin
          up_limit_r <= cfg_limit;
          up_lq_r    <= cfg_lq;
          up_lr_r    <= cfg_rem[9:0];
        end
        CFG_DOWN_LIMIT: begin
          down_limit_r <= cfg_limit;
          down_lq_r    <= cfg_lq;
          down_lr_r    <= cfg_rem[9:0];
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: each stage loads when empty or when it hands on
  // --------------------------------------------------------------------------
  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r, out_valid_r;
  logic a_free, b_free, c_free, d_free, o_free;
  logic in_fire, a_move, b_move, c_move, d_move;

  assign o_free  = !out_valid_r || out_ch.ready;
  assign d_free  = !d_valid_r || o_free;
  assign c_free  = !c_valid_r || d_free;
  assign b_free  = !b_valid_r || c_free;
  assign a_free  = !a_valid_r || b_free;

  assign in_ch.ready = a_free;
  assign in_fire = in_ch.valid && a_free;
  assign a_move  = a_valid_r && b_free;
  assign b_move  = b_valid_r && c_free;
  assign c_move  = c_valid_r && d_free;
  assign d_move  = d_valid_r && o_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)      a_valid_r <= 1'b1;
      else if (a_move)  a_valid_r <= 1'b0;
      if (a_move)       b_valid_r <= 1'b1;
      else if (b_move)  b_valid_r <= 1'b0;
      if (b_move)       c_valid_r <= 1'b1;
      else if (c_move)  c_valid_r <= 1'b0;
      if (c_move)       d_valid_r <= 1'b1;
      else if (d_move)  d_valid_r <= 1'b0;
      if (d_move)             out_valid_r <= 1'b1;
      else if (out_ch.ready)  out_valid_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input register, refill decision, elapsed / 1000
  // --------------------------------------------------------------------------
  logic [NOW_W-1:0]   a_now_r;
  logic [SPEND_W-1:0] a_up_spend_r, a_down_spend_r;
  logic [NOW_W-1:0]   last_refill_r;
  logic               time_seen_r;

  logic [NOW_W-1:0]   a_elapsed;
  logic               a_refill;
  logic [60:0]        a_q_prod;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_now_r        <= in_ch.now_ms;
      a_up_spend_r   <= in_ch.up_spend;
      a_down_spend_r <= in_ch.down_spend;
    end
  end

  always_comb begin
    a_elapsed = a_now_r - last_refill_r;
    a_refill  = time_seen_r && (a_elapsed >= REFILL_PERIOD_MS);
    a_q_prod  = 61'(a_elapsed) * 61'(DIV1000_MAGIC);
  end

  // First transaction records its time; later ones move it on refill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_seen_r   <= 1'b0;
      last_refill_r <= '0;
    end else if (a_move) begin
      if (!time_seen_r) begin
        time_seen_r   <= 1'b1;
        last_refill_r <= a_now_r;
      end else if (a_refill) begin
        last_refill_r <= a_now_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: remainder by 1000 and partial products per bucket
  //   gain = eq*L + er*Lq + floor(er*Lr / 1000)
  // --------------------------------------------------------------------------
  logic [NOW_W-1:0]   b_elapsed_r;
  logic [22:0]        b_eq_r;
  logic               b_refill_r;
  logic [SPEND_W-1:0] b_up_spend_r, b_down_spend_r;

  logic [NOW_W-1:0]   b_rem_full;
  logic [9:0]         b_er;
  logic [28:0]        b_up_p3, b_down_p3;

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_elapsed_r    <= a_elapsed;
      b_eq_r         <= a_q_prod[DIV1000_SHIFT +: 23];
      b_refill_r     <= a_refill;
      b_up_spend_r   <= a_up_spend_r;
      b_down_spend_r <= a_down_spend_r;
    end
  end

  always_comb begin
    b_rem_full = b_elapsed_r - (32'(b_eq_r) * 32'd1000);
    b_er       = b_rem_full[9:0];
    b_up_p3    = 29'(b_er) * 29'(up_lq_r);
    b_down_p3  = 29'(b_er) * 29'(down_lq_r);
  end

  logic [50:0]        c_up_t1_r, c_down_t1_r;
  logic [27:0]        c_up_t3_r, c_down_t3_r;
  logic [19:0]        c_up_t4_r, c_down_t4_r;
  logic               c_refill_r;
  logic [SPEND_W-1:0] c_up_spend_r, c_down_spend_r;

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_up_t1_r      <= 51'(b_eq_r) * 51'(up_limit_r);
      c_down_t1_r    <= 51'(b_eq_r) * 51'(down_limit_r);
      c_up_t3_r      <= b_up_p3[27:0];
      c_down_t3_r    <= b_down_p3[27:0];
      c_up_t4_r      <= 20'(b_er) * 20'(up_lr_r);
      c_down_t4_r    <= 20'(b_er) * 20'(down_lr_r);
      c_refill_r     <= b_refill_r;
      c_up_spend_r   <= b_up_spend_r;
      c_down_spend_r <= b_down_spend_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: finish the gain
  // --------------------------------------------------------------------------
  logic [32:0]        d_up_gain_r, d_down_gain_r;
  logic               d_refill_r;
  logic [SPEND_W-1:0] d_up_spend_r, d_down_spend_r;

  always_ff @(posedge clk) begin
    if (c_move) begin
      d_up_gain_r    <= gain_finish(c_up_t1_r, c_up_t3_r, c_up_t4_r);
      d_down_gain_r  <= gain_finish(c_down_t1_r, c_down_t3_r, c_down_t4_r);
      d_refill_r     <= c_refill_r;
      d_up_spend_r   <= c_up_spend_r;
      d_down_spend_r <= c_down_spend_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: bucket update and output register
  // --------------------------------------------------------------------------
  logic signed [LEFT_W-1:0] up_bucket_r, down_bucket_r;
  logic signed [LEFT_W-1:0] up_bucket_nxt, down_bucket_nxt;
  logic signed [LEFT_W-1:0] out_up_left_r, out_down_left_r;
  logic                     out_refilled_r;

  always_comb begin
    up_bucket_nxt   = bucket_step(up_bucket_r, d_up_gain_r, d_refill_r,
                                  up_limit_r, d_up_spend_r);
    down_bucket_nxt = bucket_step(down_bucket_r, d_down_gain_r, d_refill_r,
                                  down_limit_r, d_down_spend_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_bucket_r   <= $signed(32'(LIMIT_DEFAULT));
      down_bucket_r <= $signed(32'(LIMIT_DEFAULT));
    end else if (d_move) begin
      up_bucket_r   <= up_bucket_nxt;
      down_bucket_r <= down_bucket_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (d_move) begin
      out_up_left_r   <= up_bucket_nxt;
      out_down_left_r <= down_bucket_nxt;
      out_refilled_r  <= d_refill_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.up_left   = out_up_left_r;
  assign out_ch.down_left = out_down_left_r;
  assign out_ch.refilled  = out_refilled_r;

endmodule

// File: design/dtbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbl_checker - port-level checks for the dual token bucket limiter
// Watches the top level's channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module dtbl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [dtbl_pkg::LEFT_W-1:0] out_up_left,
  input logic signed [dtbl_pkg::LEFT_W-1:0] out_down_left,
  input logic                               out_refilled
);
  import dtbl_pkg::*;

  // Reset empties the output register
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A free output side never holds back the input
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side ready");

  // Credit never exceeds the largest cap
  a_credit_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_up_left <= $signed(32'(LIMIT_DEFAULT)))
               && (out_down_left <= $signed(32'(LIMIT_DEFAULT))))
    else $error("credit above cap");

  // Stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_up_left)
      && $stable(out_down_left) && $stable(out_refilled))
    else $error("stalled result changed");

endmodule

bind dual_token_bucket_limiter_top dtbl_checker u_dtbl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_up_left  (out_ch.up_left),
  .out_down_left(out_ch.down_left),
  .out_refilled (out_ch.refilled)
);

// File: verif/tb_dual_token_bucket_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_token_bucket_limiter_top - self-checking bench for the limiter
// Drives accounting transactions through a queue-fed driver and checks every
// result against a cycle-free model of both buckets. Covers the first-event
// case, exact refill spacing, clock wrap and step-back, the limit extremes
// and written zeros, writes to unused register indexes, deep negative credit
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_dual_token_bucket_limiter_top;
  import dtbl_pkg::*;

  // Register indexes that the block has no register behind
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam longint BUCKET_FLOOR = -64'sd2147483648;
  localparam logic [SPEND_W-1:0] SPEND_MAX = '1;

  typedef struct packed {
    logic [NOW_W-1:0]   now_ms;
    logic [SPEND_W-1:0] up_spend;
    logic [SPEND_W-1:0] down_spend;
  } acct_t;

  typedef struct packed {
    logic signed [LEFT_W-1:0] up_left;
    logic signed [LEFT_W-1:0] down_left;
    logic                     refilled;
  } credit_t;

  logic clk = 1'b0;
  logic rst_n;

  dtbl_in_if  in_if();
  dtbl_out_if out_if();
  dtbl_cfg_if cfg_if();

  dual_token_bucket_limiter_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bucket model: its own copy of the limits and of the bucket state
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] lim_up  = LIMIT_DEFAULT;
  logic [LIMIT_W-1:0] lim_dn  = LIMIT_DEFAULT;
  logic [NOW_W-1:0]   ref_ms  = '0;
  logic               have_time = 1'b0;
  longint             bkt_up  = longint'(LIMIT_DEFAULT);
  longint             bkt_dn  = longint'(LIMIT_DEFAULT);

  acct_t   pending[$];   // accounting events not yet offered to the block
  credit_t credit_q[$];  // credit the block owes, oldest first

  int unsigned mism_count = 0;

  // Stimulus-side knobs, changed from the test sequence
  logic        in_gaps_on   = 1'b0;
  logic        out_stall_on = 1'b0;
  logic        choke        = 1'b0;
  logic [NOW_W-1:0] stamp   = '0;

  // Add the time-based gain, then cap at the limit
  function automatic longint top_up(longint b, logic [NOW_W-1:0] el,
                                    logic [LIMIT_W-1:0] lim);
    longint unsigned gain;
    longint          s;
    gain = (64'(el) * 64'(lim)) / 64'd1000;
    s = b + longint'(gain);
    if (s > longint'(lim)) s = longint'(lim);
    return s;
  endfunction

  // Take the spend off, saturating at the bottom of the 32-bit range
  function automatic longint take_spend(longint b, logic [SPEND_W-1:0] sp);
    longint r;
    r = b - longint'(sp);
    if (r < BUCKET_FLOOR) r = BUCKET_FLOOR;
    return r;
  endfunction

  // Advance the model by one accepted event and queue the credit it owes
  function automatic void account_event(acct_t ev);
    credit_t          c;
    logic [NOW_W-1:0] el;
    c.refilled = 1'b0;
    if (!have_time) begin
      have_time = 1'b1;
      ref_ms    = ev.now_ms;
    end else begin
      el = ev.now_ms - ref_ms;
      if (el >= REFILL_PERIOD_MS) begin
        bkt_up     = top_up(bkt_up, el, lim_up);
        bkt_dn     = top_up(bkt_dn, el, lim_dn);
        ref_ms     = ev.now_ms;
        c.refilled = 1'b1;
      end
    end
    bkt_up = take_spend(bkt_up, ev.up_spend);
    bkt_dn = take_spend(bkt_dn, ev.down_spend);
    c.up_left   = bkt_up[LEFT_W-1:0];
    c.down_left = bkt_dn[LEFT_W-1:0];
    credit_q.push_back(c);
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else             return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer pending events, predict each one at its handshake
  // --------------------------------------------------------------------------
  acct_t       offer;
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    logic busy;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      busy = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        account_event(offer);
        busy = 1'b0;
      end
      // Hold the current transaction until it is taken
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          offer = pending.pop_front();
          in_if.now_ms     <= offer.now_ms;
          in_if.up_spend   <= offer.up_spend;
          in_if.down_spend <= offer.down_spend;
          in_if.valid      <= 1'b1;
          in_gap           <= in_gaps_on ? pause_len() : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest owed credit
  // --------------------------------------------------------------------------
  int unsigned out_stall = 0;

  always @(posedge clk) begin
    credit_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (credit_q.size() == 0) begin
          $error("result with no credit owed: up_left %0d down_left %0d refilled %0b",
                 out_if.up_left, out_if.down_left, out_if.refilled);
          mism_count++;
        end else begin
          want = credit_q.pop_front();
          if (out_if.up_left !== want.up_left) begin
            $error("up_left mismatch: expected %0d, actual %0d",
                   want.up_left, out_if.up_left);
            mism_count++;
          end
          if (out_if.down_left !== want.down_left) begin
            $error("down_left mismatch: expected %0d, actual %0d",
                   want.down_left, out_if.down_left);
            mism_count++;
          end
          if (out_if.refilled !== want.refilled) begin
            $error("refilled mismatch: expected %0b, actual %0b",
                   want.refilled, out_if.refilled);
            mism_count++;
          end
        end
      end
      // The long hold-off wins over everything, then random stalls
      if (choke) begin
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall    <= out_stall - 1;
        out_if.ready <= 1'b0;
      end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
        out_stall    <= pause_len();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_event(logic [NOW_W-1:0] t, logic [SPEND_W-1:0] up,
                                     logic [SPEND_W-1:0] dn);
    acct_t ev;
    ev.now_ms     = t;
    ev.up_spend   = up;
    ev.down_spend = dn;
    pending.push_back(ev);
  endfunction

  function automatic logic [SPEND_W-1:0] rand_spend();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15)      return '0;
    else if (r < 25) return SPEND_MAX;
    else if (r < 60) return SPEND_W'($urandom_range(0, 4095));
    else             return SPEND_W'($urandom_range(0, SPEND_MAX));
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)      return '0;
    else if (r < 20) return LIMIT_W'(1);
    else if (r < 35) return LIMIT_DEFAULT;
    else if (r < 65) return LIMIT_W'($urandom_range(1, 5000));
    else             return LIMIT_W'($urandom_range(0, LIMIT_DEFAULT));
  endfunction

  // Step the clock by a mix of short, exact-period, long and wild amounts
  task automatic push_random(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 25)      stamp = stamp + $urandom_range(0, 499);
      else if (r < 35) stamp = stamp;
      else if (r < 45) stamp = stamp + REFILL_PERIOD_MS;
      else if (r < 75) stamp = stamp + $urandom_range(500, 3000);
      else if (r < 90) stamp = stamp + $urandom_range(3000, 100000);
      else             stamp = $urandom();
      push_event(stamp, rand_spend(), rand_spend());
    end
  endtask

  // Wait until nothing is in flight, then let the pipeline go quiet
  task automatic settle();
    do @(negedge clk);
    while (pending.size() != 0 || in_if.valid || credit_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // One register write; the model follows at the handshake
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    logic [LIMIT_W-1:0] folded;
    @(posedge clk);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_if.ready);
    folded = (val == '0) ? LIMIT_DEFAULT : val;
    case (idx)
      CFG_UP_LIMIT:   lim_up = folded;
      CFG_DOWN_LIMIT: lim_dn = folded;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [NOW_W-1:0] t0;
    logic [NOW_W-1:0] base;

    // Drive every input to a known value before the first edge
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.now_ms     = '0;
    in_if.up_spend   = '0;
    in_if.down_spend = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    // Reset limits. The first event only records its time; then hit the
    // period one short and exactly, cross the wrap, and step the clock back.
    t0 = 32'hFFFF_FE00;
    push_event(t0, SPEND_MAX, '0);
    push_event(t0, '0, SPEND_MAX);
    push_event(t0 + 499, 20'd1, 20'd1);
    push_event(t0 + 500, '0, '0);
    push_event(t0 + 1000, SPEND_MAX, SPEND_MAX);
    push_event(t0 + 999, '0, '0);
    push_event(32'hFFFF_FFFF, 20'h55555, 20'hAAAAA);
    push_event(32'h0000_0000, 20'hAAAAA, 20'h55555);
    settle();

    // Written zero on one side, the smallest limit on the other, and
    // writes to indexes with no register behind them.
    write_reg(CFG_UP_LIMIT, '0);
    write_reg(CFG_DOWN_LIMIT, LIMIT_W'(1));
    write_reg(CFG_SPARE_A, LIMIT_DEFAULT);
    write_reg(CFG_SPARE_B, LIMIT_W'($urandom()));
    base = 32'h8000_0000;
    push_event(base, '0, '0);
    push_event(base + 500, '0, '0);
    push_event(base + 1999, '0, 20'd1);
    push_event(base + 4000, '0, '0);
    push_event(base + 4000, SPEND_MAX, SPEND_MAX);
    settle();

    // New limits apply at once but do not re-cap until the next refill
    write_reg(CFG_UP_LIMIT, LIMIT_DEFAULT);
    write_reg(CFG_DOWN_LIMIT, '0);
    push_event(base + 4100, '0, '0);
    push_event(base + 4600, '0, '0);
    settle();

    // Random phases: vary the idling, and choke the receiver in one of them
    stamp = base + 5000;
    for (int ph = 0; ph < 4; ph++) begin
      in_gaps_on   = (ph != 1);
      out_stall_on = (ph != 1) && (ph != 2);
      write_reg(CFG_UP_LIMIT, rand_limit());
      write_reg(CFG_DOWN_LIMIT, rand_limit());
      if (ph == 3) write_reg(CFG_SPARE_B, LIMIT_W'($urandom()));
      push_random(220);
      if (ph == 2) begin
        // Hold the receiver off while the sender keeps offering back to back
        in_gaps_on = 1'b0;
        choke      = 1'b1;
        repeat (300) @(negedge clk);
        choke      = 1'b0;
      end
      settle();
    end

    // Run both buckets deep into debt: smallest limits, no refill after the
    // first event, near-maximum spends on the events that follow it.
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    write_reg(CFG_UP_LIMIT, LIMIT_W'(1));
    write_reg(CFG_DOWN_LIMIT, LIMIT_W'(1));
    base = ref_ms + 1000;
    push_event(base, '0, '0);
    repeat (200)
      push_event(base + $urandom_range(0, 499),
                 SPEND_W'($urandom_range(20'hF8000, SPEND_MAX)),
                 SPEND_W'($urandom_range(20'hF8000, SPEND_MAX)));
    // Step back: the longest elapsed time pays back part of the debt
    push_event(base - 1, '0, '0);
    settle();

    // Largest limits: a step back from deep debt refills to the cap
    write_reg(CFG_UP_LIMIT, LIMIT_DEFAULT);
    write_reg(CFG_DOWN_LIMIT, '0);
    push_event(ref_ms - 1, '0, SPEND_MAX);
    stamp = ref_ms;
    push_random(50);
    settle();

    if (mism_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
